// File: src/tccw_pkg.sv
// ---------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console cell writer
// Screen geometry, widths, character codes, register map, sequencer states
// and the screen memory request bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int CELL_W  = 16;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  localparam logic [CELL_W-1:0] ATTR_RESET  = 16'h0700;
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_CHAR_ATTR = 1'b0;
  localparam logic REG_BLANK     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_SCROLL_TAIL,
    ST_FILL,
    ST_BLANK
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

`default_nettype wire

// File: src/tccw_ram.sv
// ---------------------------------------------------------------------------
// tccw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/tccw_ctrl.sv
// ---------------------------------------------------------------------------
// tccw_ctrl: cursor and screen sequencer
// Holds the cursor, steps the screen memory through character writes,
// cell reads, the row-by-row scroll move, the bottom-row fill and the
// clearing pass after reset, and registers the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           opcode,
  input  wire logic [tccw_pkg::CHAR_W-1:0]    char_code,
  input  wire logic [tccw_pkg::IDX_W-1:0]     cell_index,
  input  wire logic [tccw_pkg::CELL_W-1:0]    char_attribute,
  input  wire logic [tccw_pkg::CELL_W-1:0]    blank_cell,
  input  wire logic [tccw_pkg::CELL_W-1:0]    rdata,
  output tccw_pkg::mem_req_t                  mem_req,
  output logic                                busy,
  output logic                                done,
  output logic      [tccw_pkg::ROW_W-1:0]     cursor_row,
  output logic      [tccw_pkg::COL_W-1:0]     cursor_column,
  output logic      [tccw_pkg::CELL_W-1:0]    read_value,
  output logic                                scrolled
);

  localparam int AW = tccw_pkg::ADDR_W;

  tccw_pkg::state_t state, state_next;

  logic                          op_q;
  logic [tccw_pkg::CHAR_W-1:0]   ch_q;
  logic [tccw_pkg::IDX_W-1:0]    idx_q;
  logic [tccw_pkg::ROW_W-1:0]    row, row_next;
  logic [tccw_pkg::COL_W-1:0]    col, col_next;
  logic [AW-1:0]                 cnt, cnt_next;
  logic                          wb_valid, wb_valid_next;
  logic [AW-1:0]                 wb_addr, wb_addr_next;
  logic                          scr_q, scr_next;
  logic                          done_next;
  logic [tccw_pkg::CELL_W-1:0]   read_next;
  logic                          advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tccw_pkg::ST_CLEAR;
      row      <= '0;
      col      <= '0;
      cnt      <= '0;
      wb_valid <= 1'b0;
      scr_q    <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      row      <= row_next;
      col      <= col_next;
      cnt      <= cnt_next;
      wb_valid <= wb_valid_next;
      scr_q    <= scr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= wb_addr_next;
    if (state == tccw_pkg::ST_IDLE && start) begin
      op_q  <= opcode;
      ch_q  <= char_code;
      idx_q <= cell_index;
    end
    if (done_next) begin
      cursor_row    <= row_next;
      cursor_column <= col_next;
      read_value    <= read_next;
      scrolled      <= scr_next;
    end
  end

  assign busy = (state != tccw_pkg::ST_IDLE);

  always_comb begin
    state_next    = state;
    row_next      = row;
    col_next      = col;
    cnt_next      = cnt;
    scr_next      = scr_q;
    done_next     = 1'b0;
    read_next     = '0;
    advance       = 1'b0;
    wb_valid_next = 1'b0;
    wb_addr_next  = cnt - AW'(tccw_pkg::COLUMNS);
    mem_req       = '0;

    // A moved cell is written in the cycle after its read address was issued.
    if (wb_valid) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = wb_addr;
      mem_req.wdata = rdata;
    end

    unique case (state)
      tccw_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt;
        mem_req.wdata = tccw_pkg::BLANK_RESET;
        if (cnt == AW'(tccw_pkg::CELLS - 1)) begin
          cnt_next   = '0;
          state_next = tccw_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccw_pkg::ST_IDLE: begin
        if (start) begin
          state_next = tccw_pkg::ST_EXEC;
        end
      end

      tccw_pkg::ST_EXEC: begin
        scr_next = 1'b0;
        if (op_q == tccw_pkg::OP_READ) begin
          if (idx_q < tccw_pkg::IDX_W'(tccw_pkg::CELLS)) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_q[AW-1:0];
            state_next    = tccw_pkg::ST_READ_WAIT;
          end else begin
            done_next  = 1'b1;
            state_next = tccw_pkg::ST_IDLE;
          end
        end else begin
          priority if (ch_q == tccw_pkg::CH_NEWLINE) begin
            col_next = '0;
            advance  = 1'b1;
          end else if (ch_q == tccw_pkg::CH_BACKSPACE) begin
            if (col != '0) begin
              col_next = col - 1'b1;
            end
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = tccw_pkg::cell_addr(row, col);
            mem_req.wdata = char_attribute | tccw_pkg::CELL_W'(ch_q);
            if (col == tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1)) begin
              col_next = '0;
              advance  = 1'b1;
            end else begin
              col_next = col + 1'b1;
            end
          end
          // Stepping past the last row keeps the cursor there and scrolls.
          if (advance && row == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)) begin
            scr_next   = 1'b1;
            cnt_next   = AW'(tccw_pkg::COLUMNS);
            state_next = tccw_pkg::ST_SCROLL;
          end else begin
            if (advance) begin
              row_next = row + 1'b1;
            end
            state_next = tccw_pkg::ST_BLANK;
          end
        end
      end

      tccw_pkg::ST_READ_WAIT: begin
        read_next  = rdata;
        done_next  = 1'b1;
        state_next = tccw_pkg::ST_IDLE;
      end

      tccw_pkg::ST_SCROLL: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cnt;
        wb_valid_next = 1'b1;
        if (cnt == AW'(tccw_pkg::CELLS - 1)) begin
          state_next = tccw_pkg::ST_SCROLL_TAIL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccw_pkg::ST_SCROLL_TAIL: begin
        cnt_next   = AW'((tccw_pkg::ROWS - 1) * tccw_pkg::COLUMNS);
        state_next = tccw_pkg::ST_FILL;
      end

      tccw_pkg::ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt;
        mem_req.wdata = blank_cell;
        if (cnt == AW'(tccw_pkg::CELLS - 1)) begin
          state_next = tccw_pkg::ST_BLANK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccw_pkg::ST_BLANK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = tccw_pkg::cell_addr(row, col);
        mem_req.wdata = blank_cell;
        done_next     = 1'b1;
        state_next    = tccw_pkg::ST_IDLE;
      end

      default: begin
        state_next = tccw_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && state == tccw_pkg::ST_EXEC))
    else $error("accepted word did not start the sequencer");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (cursor_row < tccw_pkg::ROW_W'(tccw_pkg::ROWS) &&
              cursor_column < tccw_pkg::COL_W'(tccw_pkg::COLUMNS)))
    else $error("cursor left the screen");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (done && scrolled) |-> (cursor_row == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)))
    else $error("scroll did not hold the cursor on the last row");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == tccw_pkg::ST_BLANK ||
              $past(state) == tccw_pkg::ST_READ_WAIT ||
              $past(state) == tccw_pkg::ST_EXEC))
    else $error("result strobe from an unexpected state");

  a_move_write: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> ($past(state) == tccw_pkg::ST_SCROLL))
    else $error("scroll write without a matching read");

endmodule

`default_nettype wire

// File: src/text_console_cell_writer_unit.sv
// ---------------------------------------------------------------------------
// text_console_cell_writer_unit: text-mode console cell writer
// An 80x25 screen of 16-bit cells with a cursor, printing, newline,
// backspace, scrolling and single-cell reads, plus an APB register port.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its one result appears
// with done for a single cycle and must be captured then. All screen traffic
// goes through one screen memory with one write and one read port. A put that
// scrolls moves 24 rows one cell per cycle and then fills the bottom row. After
// reset busy stays high while every cell is cleared to 0x0720; register writes
// are taken during that time.
`default_nettype none

module text_console_cell_writer_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               opcode,
  input  wire logic [tccw_pkg::CHAR_W-1:0]        char_code,
  input  wire logic [tccw_pkg::IDX_W-1:0]         cell_index,
  output logic                                    done,
  output logic      [tccw_pkg::ROW_W-1:0]         cursor_row,
  output logic      [tccw_pkg::COL_W-1:0]         cursor_column,
  output logic      [tccw_pkg::CELL_W-1:0]        read_value,
  output logic                                    scrolled,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tccw_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [tccw_pkg::PDATA_W-1:0]       pwdata,
  output logic      [tccw_pkg::PDATA_W-1:0]       prdata,
  output logic                                    pready
);

  logic [tccw_pkg::CELL_W-1:0] char_attribute;
  logic [tccw_pkg::CELL_W-1:0] blank_cell;
  logic [tccw_pkg::CELL_W-1:0] rdata;
  tccw_pkg::mem_req_t          mem_req;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_attribute <= tccw_pkg::ATTR_RESET;
      blank_cell     <= tccw_pkg::BLANK_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        tccw_pkg::REG_CHAR_ATTR: char_attribute <= pwdata[tccw_pkg::CELL_W-1:0];
        tccw_pkg::REG_BLANK:     blank_cell     <= pwdata[tccw_pkg::CELL_W-1:0];
        default:                 char_attribute <= char_attribute;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tccw_pkg::REG_CHAR_ATTR: prdata = tccw_pkg::PDATA_W'(char_attribute);
      tccw_pkg::REG_BLANK:     prdata = tccw_pkg::PDATA_W'(blank_cell);
      default:                 prdata = '0;
    endcase
  end

  tccw_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .opcode         (opcode),
    .char_code      (char_code),
    .cell_index     (cell_index),
    .char_attribute (char_attribute),
    .blank_cell     (blank_cell),
    .rdata          (rdata),
    .mem_req        (mem_req),
    .busy           (busy),
    .done           (done),
    .cursor_row     (cursor_row),
    .cursor_column  (cursor_column),
    .read_value     (read_value),
    .scrolled       (scrolled)
  );

  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_W),
    .DEPTH (tccw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire
